### design/wbs_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner package
// Shared types and constants for the scanner, its register block and stages.
// ----------------------------------------------------------------------------
`default_nettype none

package wbs_pkg;

    // Signature bytes held in the configuration registers.
    localparam int SIG_BYTES = 16;

    localparam logic [7:0] BYTE_RET = 8'hC3;
    localparam logic [7:0] BYTE_PAD = 8'hCC;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_RESULT_OFS   = 3'd4,
        REG_SCAN_START   = 3'd5
    } t_reg_idx;

    // Byte i of the signature sits in pattern[8*i +: 8].
    typedef struct packed {
        logic [8*SIG_BYTES-1:0] pattern;
        logic [SIG_BYTES-1:0]   care_mask;
        logic [4:0]             pattern_length;
        logic signed [31:0]     result_offset;
        logic [31:0]            scan_start;
    } t_cfg;

    // Control of the item held in the window stage.
    typedef struct packed {
        logic        vld;
        logic        last;
        logic [31:0] pos;
    } t_s1_ctl;

endpackage

`default_nettype wire

### design/wildcard_byte_signature_scanner.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner
// Streams a memory image one byte per transaction, guesses function starts
// and reports the preferred match of a masked signature at the final byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; input stalls only while a finished result
//   waits in the result register and the next final byte wants to follow it.
// Result path: a final byte passes the window register, then the compare and
//   result register, before the result appears at the outputs.
// Reset: synchronous, active low; clears stream state and loads register
//   defaults (care mask 1, pattern length 1, all others 0).
`default_nettype none

module wildcard_byte_signature_scanner
    import wbs_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_in_code_section,
    input  wire logic                  i_last_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_found,
    output logic signed [33:0]         o_match_address,
    output logic                       o_at_function_start
);

    t_cfg                           cfg;
    t_s1_ctl                        s1;
    logic [8*MAX_PATTERN_BYTES-1:0] win;
    logic [MAX_PATTERN_BYTES-1:0]   mark;
    logic                           accept;
    logic                           advance;

    // A non-final byte always moves on; a final byte needs the result register.
    assign advance    = s1.vld && (!s1.last || !o_out_valid || !i_out_stall);
    assign o_in_stall = s1.vld && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    wbs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wbs_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_advance         (advance),
        .i_data_byte       (i_data_byte),
        .i_in_code_section (i_in_code_section),
        .i_last_byte       (i_last_byte),
        .o_win             (win),
        .o_mark            (mark),
        .o_s1              (s1)
    );

    wbs_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_win               (win),
        .i_mark              (mark),
        .i_s1                (s1),
        .i_advance           (advance),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_found             (o_found),
        .o_match_address     (o_match_address),
        .o_at_function_start (o_at_function_start)
    );

endmodule

`default_nettype wire

### design/wbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Scanner configuration registers
// APB-style register file holding the signature, care mask and scan controls.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_cfg_regs
    import wbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern        <= '0;
            r_cfg.care_mask      <= SIG_BYTES'(1);
            r_cfg.pattern_length <= 5'd1;
            r_cfg.result_offset  <= '0;
            r_cfg.scan_start     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PATTERN_LOW:  r_cfg.pattern[63:0]    <= pwdata;
                REG_PATTERN_HIGH: r_cfg.pattern[127:64]  <= pwdata;
                REG_CARE_MASK:    r_cfg.care_mask        <= pwdata[SIG_BYTES-1:0];
                REG_PATTERN_LEN:  r_cfg.pattern_length   <= pwdata[4:0];
                REG_RESULT_OFS:   r_cfg.result_offset    <= pwdata[31:0];
                REG_SCAN_START:   r_cfg.scan_start       <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PATTERN_LOW:  prdata = r_cfg.pattern[63:0];
            REG_PATTERN_HIGH: prdata = r_cfg.pattern[127:64];
            REG_CARE_MASK:    prdata = APB_DATA_W'(r_cfg.care_mask);
            REG_PATTERN_LEN:  prdata = APB_DATA_W'(r_cfg.pattern_length);
            REG_RESULT_OFS:   prdata = APB_DATA_W'(unsigned'(r_cfg.result_offset));
            REG_SCAN_START:   prdata = APB_DATA_W'(r_cfg.scan_start);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### design/wbs_window.sv
// ----------------------------------------------------------------------------
// Scanner byte window stage
// Registers each accepted byte into the history window, tracks the guessed
// function state and numbers the bytes of the image.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_window
    import wbs_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_advance,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_in_code_section,
    input  wire logic                           i_last_byte,
    output logic      [8*MAX_PATTERN_BYTES-1:0] o_win,
    output logic      [MAX_PATTERN_BYTES-1:0]   o_mark,
    output t_s1_ctl                             o_s1
);

    logic [8*MAX_PATTERN_BYTES-1:0] r_win, n_win;
    logic [MAX_PATTERN_BYTES-1:0]   r_mark, n_mark;
    logic                           r_inside, n_inside;
    t_s1_ctl                        r_s1;
    logic                           fresh;
    logic                           mark;
    logic [31:0]                    n_pos;

    // After the final byte of an image the next byte starts from a clean history.
    assign fresh = r_s1.last;

    always_comb begin
        mark     = 1'b0;
        n_inside = fresh ? 1'b0 : r_inside;
        if (!i_in_code_section) begin
            n_inside = 1'b0;
        end else if (n_inside) begin
            if (i_data_byte == BYTE_RET) begin
                n_inside = 1'b0;
            end
        end else if (i_data_byte != BYTE_PAD) begin
            n_inside = 1'b1;
            mark     = 1'b1;
        end

        n_pos = fresh ? 32'd0 : r_s1.pos + 32'd1;

        n_win[7:0] = i_data_byte;
        n_mark[0]  = mark;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            n_win[8*k +: 8] = fresh ? 8'd0 : r_win[8*(k-1) +: 8];
            n_mark[k]       = fresh ? 1'b0 : r_mark[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld  <= 1'b0;
            r_s1.last <= 1'b1;
            r_s1.pos  <= '0;
            r_inside  <= 1'b0;
            r_mark    <= '0;
        end else begin
            if (i_accept) begin
                r_s1.vld  <= 1'b1;
                r_s1.last <= i_last_byte;
                r_s1.pos  <= n_pos;
                r_inside  <= n_inside;
                r_mark    <= n_mark;
            end else if (i_advance) begin
                r_s1.vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

    assign o_win  = r_win;
    assign o_mark = r_mark;
    assign o_s1   = r_s1;

endmodule

`default_nettype wire

### design/wbs_match.sv
// ----------------------------------------------------------------------------
// Scanner match and result stage
// Compares the window against the masked signature, keeps the earliest
// function-start and scan_start-bounded matches, and registers the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_match
    import wbs_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_cfg                           i_cfg,
    input  wire logic [8*MAX_PATTERN_BYTES-1:0] i_win,
    input  wire logic [MAX_PATTERN_BYTES-1:0]   i_mark,
    input  wire t_s1_ctl                        i_s1,
    input  wire logic                           i_advance,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_found,
    output logic signed [33:0]                  o_match_address,
    output logic                                o_at_function_start
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [LEN_W-1:0]   len;
    logic [IDX_W-1:0]   lenm1;
    logic [IDX_W-1:0]   j;
    logic               hit;
    logic               elig;
    logic [31:0]        start_pos;
    logic               fn_take, im_take;

    logic               r_fm_vld, n_fm_vld;
    logic [31:0]        r_fm_pos, n_fm_pos;
    logic               r_im_vld, n_im_vld;
    logic [31:0]        r_im_pos, n_im_pos;

    logic               r_out_vld;
    logic               r_found, n_found;
    logic signed [33:0] r_addr, n_addr;
    logic               r_afs, n_afs;

    // Length zero acts as one; lengths past the window depth are clamped.
    always_comb begin
        if (i_cfg.pattern_length == 5'd0) begin
            len = LEN_W'(1);
        end else if (32'(i_cfg.pattern_length) > 32'(MAX_PATTERN_BYTES)) begin
            len = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len = LEN_W'(i_cfg.pattern_length);
        end
        lenm1 = IDX_W'(len - LEN_W'(1));
    end

    // Window slot 0 holds the newest byte, so signature byte i lines up with
    // slot len-1-i. Signature bytes past the register width are wildcards.
    always_comb begin
        hit = 1'b1;
        j   = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            j = lenm1 - IDX_W'(i);
            if ((LEN_W'(i) < len) && (i < SIG_BYTES) &&
                i_cfg.care_mask[i % SIG_BYTES] &&
                (i_win[8*j +: 8] != i_cfg.pattern[8*(i % SIG_BYTES) +: 8])) begin
                hit = 1'b0;
            end
        end
    end

    assign elig      = i_s1.pos >= 32'(lenm1);
    assign start_pos = i_s1.pos - 32'(lenm1);
    assign fn_take   = elig && hit && i_mark[lenm1] && !r_fm_vld;
    assign im_take   = elig && hit && (start_pos >= i_cfg.scan_start) && !r_im_vld;

    always_comb begin
        n_fm_vld = r_fm_vld || fn_take;
        n_fm_pos = fn_take ? start_pos : r_fm_pos;
        n_im_vld = r_im_vld || im_take;
        n_im_pos = im_take ? start_pos : r_im_pos;

        n_found = 1'b0;
        n_addr  = '0;
        n_afs   = 1'b0;
        if (n_fm_vld) begin
            n_found = 1'b1;
            n_addr  = signed'({2'b00, n_fm_pos});
            n_afs   = 1'b1;
        end else if (n_im_vld) begin
            n_found = 1'b1;
            n_addr  = signed'({2'b00, n_im_pos}) +
                      signed'({{2{i_cfg.result_offset[31]}}, i_cfg.result_offset});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm_vld  <= 1'b0;
            r_fm_pos  <= '0;
            r_im_vld  <= 1'b0;
            r_im_pos  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_advance) begin
                if (i_s1.last) begin
                    r_fm_vld <= 1'b0;
                    r_fm_pos <= '0;
                    r_im_vld <= 1'b0;
                    r_im_pos <= '0;
                end else begin
                    r_fm_vld <= n_fm_vld;
                    r_fm_pos <= n_fm_pos;
                    r_im_vld <= n_im_vld;
                    r_im_pos <= n_im_pos;
                end
            end
            if (i_advance && i_s1.last) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_s1.last) begin
            r_found <= n_found;
            r_addr  <= n_addr;
            r_afs   <= n_afs;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_found             = r_found;
    assign o_match_address     = r_addr;
    assign o_at_function_start = r_afs;

    a_afs_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_afs |-> r_found)
        else $error("function-start result without a match");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_found |-> (r_addr == 34'sd0) && !r_afs)
        else $error("empty result carries a nonzero address");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_advance && i_s1.last))
        else $error("result appeared without a final byte");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_s1.last |=> !r_fm_vld && !r_im_vld)
        else $error("match state not cleared after final byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_s1.last |-> !r_out_vld || !i_out_stall)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the wildcard byte signature scanner
// Streams memory images through the scanner under a series of register
// settings and random back-pressure. A scoreboard tracks function starts and
// signature matches byte by byte and checks the single result of each image.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class scan_scoreboard;

    typedef struct packed {
        logic        found;
        logic [33:0] address;
        logic        at_fn;
    } t_verdict;

    // Register copies.
    logic [127:0] sig;
    logic [15:0]  care;
    logic [4:0]   len_reg;
    logic [31:0]  ofs;
    logic [31:0]  start;

    // Image state.
    logic [31:0]  pos;
    bit           in_func;
    logic [7:0]   window [16];
    bit           fn_marks [16];
    bit           fn_hit;
    logic [31:0]  fn_pos;
    bit           img_hit;
    logic [31:0]  img_pos;

    t_verdict     verdicts_due [$];
    int           errors;
    int           fn_verdicts;
    int           fallback_verdicts;
    int           empty_verdicts;

    function new();
        sig     = '0;
        care    = 16'h0001;
        len_reg = 5'd1;
        ofs     = '0;
        start   = '0;
        errors  = 0;
        fn_verdicts = 0;
        fallback_verdicts = 0;
        empty_verdicts = 0;
        clear_image();
    endfunction

    function void clear_image();
        pos     = '0;
        in_func = 0;
        for (int k = 0; k < 16; k++) begin
            window[k]   = '0;
            fn_marks[k] = 0;
        end
        fn_hit  = 0;
        fn_pos  = '0;
        img_hit = 0;
        img_pos = '0;
    endfunction

    function void write_reg(wbs_pkg::t_reg_idx idx, logic [63:0] value);
        case (idx)
            wbs_pkg::REG_PATTERN_LOW:  sig[63:0]   = value;
            wbs_pkg::REG_PATTERN_HIGH: sig[127:64] = value;
            wbs_pkg::REG_CARE_MASK:    care        = value[15:0];
            wbs_pkg::REG_PATTERN_LEN:  len_reg     = value[4:0];
            wbs_pkg::REG_RESULT_OFS:   ofs         = value[31:0];
            wbs_pkg::REG_SCAN_START:   start       = value[31:0];
            default: ;
        endcase
    endfunction

    // Length register clamped to what the compare window can hold.
    function int active_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > 16)
            return 16;
        return int'(len_reg);
    endfunction

    function void take_byte(logic [7:0] b, logic code, logic last);
        int       n;
        bit       hit;
        bit       mark;
        logic [31:0] s;
        t_verdict v;
        mark = 0;
        if (!code) begin
            in_func = 0;
        end else if (in_func) begin
            if (b == wbs_pkg::BYTE_RET)
                in_func = 0;
        end else if (b != wbs_pkg::BYTE_PAD) begin
            in_func = 1;
            mark    = 1;
        end
        for (int k = 15; k > 0; k--) begin
            window[k]   = window[k-1];
            fn_marks[k] = fn_marks[k-1];
        end
        window[0]   = b;
        fn_marks[0] = mark;

        n = active_len();
        if (pos >= 32'(n - 1)) begin
            s   = pos - 32'(n - 1);
            hit = 1;
            for (int i = 0; i < n; i++) begin
                if (care[i] && window[n-1-i] != sig[8*i +: 8])
                    hit = 0;
            end
            if (hit) begin
                if (fn_marks[n-1] && !fn_hit) begin
                    fn_hit = 1;
                    fn_pos = s;
                end
                if (s >= start && !img_hit) begin
                    img_hit = 1;
                    img_pos = s;
                end
            end
        end
        pos = pos + 1;

        if (last) begin
            if (fn_hit) begin
                v = '{found: 1'b1, address: {2'b00, fn_pos}, at_fn: 1'b1};
                fn_verdicts++;
            end else if (img_hit) begin
                v = '{found: 1'b1, address: {2'b00, img_pos} + {{2{ofs[31]}}, ofs},
                      at_fn: 1'b0};
                fallback_verdicts++;
            end else begin
                v = '{found: 1'b0, address: '0, at_fn: 1'b0};
                empty_verdicts++;
            end
            verdicts_due = {verdicts_due, v};
            clear_image();
        end
    endfunction

    function void check_verdict(logic found, logic [33:0] address, logic at_fn);
        t_verdict v;
        if (verdicts_due.size() == 0) begin
            $display("%0t: result with no image finished, got found=%0b address=%h fn=%0b",
                     $time, found, address, at_fn);
            errors++;
            return;
        end
        v = verdicts_due.pop_front();
        if (found !== v.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b", $time, v.found, found);
            errors++;
        end
        if (address !== v.address) begin
            $display("%0t: match_address mismatch, expected %h, got %h",
                     $time, v.address, address);
            errors++;
        end
        if (at_fn !== v.at_fn) begin
            $display("%0t: at_function_start mismatch, expected %0b, got %0b",
                     $time, v.at_fn, at_fn);
            errors++;
        end
    endfunction

endclass

module tb_top;
    import wbs_pkg::*;

    localparam int ITEM_TARGET    = 1300;
    localparam int QUIET_FROM     = 1100;
    localparam int SETTLE_CYCLES  = 5;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte;
    logic                  i_in_code_section;
    logic                  i_last_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_found;
    logic signed [33:0]    o_match_address;
    logic                  o_at_function_start;

    scan_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    int bytes_sent;
    int images_sent;
    int settings_used;
    int quiet_cycles;

    wildcard_byte_signature_scanner dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_data_byte         (i_data_byte),
        .i_in_code_section   (i_in_code_section),
        .i_last_byte         (i_last_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_found             (o_found),
        .o_match_address     (o_match_address),
        .o_at_function_start (o_at_function_start)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Both channels are observed at the rising edge, before the block updates.
    always @(posedge i_clk) begin : monitor
        bit busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.take_byte(i_data_byte, i_in_code_section, i_last_byte);
                busy = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_verdict(o_found, o_match_address, o_at_function_start);
                busy = 1'b1;
            end
            if (psel && penable)
                busy = 1'b1;
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        quiet_cycles = 0;
        @(posedge i_rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // Output back-pressure in random bursts.
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < out_idle_pct) begin
                n = $urandom_range(1, 10);
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input logic [127:0] s, input logic [15:0] c,
                               input logic [4:0] n, input logic [31:0] o,
                               input logic [31:0] st);
        reg_write(REG_PATTERN_LOW, s[63:0]);
        reg_write(REG_PATTERN_HIGH, s[127:64]);
        reg_write(REG_CARE_MASK, {48'b0, c});
        reg_write(REG_PATTERN_LEN, {59'b0, n});
        reg_write(REG_RESULT_OFS, {32'b0, o});
        reg_write(REG_SCAN_START, {32'b0, st});
        settings_used++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic code, input logic last);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_data_byte       <= b;
        i_in_code_section <= code;
        i_last_byte       <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (last)
            images_sent++;
    endtask

    // Drop valid, then wait until every image result is back and the
    // pipeline has drained, so the registers can be rewritten safely.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random image with signature copies planted in it; some copies run past
    // the end and some follow a return or padding byte to land on a function
    // start.
    task automatic send_image();
        int         n;
        int         len_img;
        int         mode;
        int         copies;
        int         q;
        int         idx;
        logic [7:0] img_b [64];
        logic       img_c [64];
        n = sb.active_len();
        len_img = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 64) : $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < len_img; k++) begin
            case (mode)
                0: img_c[k] = 1'b1;
                1: img_c[k] = 1'b0;
                default: begin
                    if (k == 0 || $urandom_range(0, 7) == 0)
                        img_c[k] = ($urandom_range(0, 1) == 1);
                    else
                        img_c[k] = img_c[k-1];
                end
            endcase
            case ($urandom_range(0, 5))
                0: img_b[k] = BYTE_PAD;
                1: img_b[k] = BYTE_RET;
                2: begin
                    idx = $urandom_range(0, 15);
                    img_b[k] = sb.sig[8*idx +: 8];
                end
                default: img_b[k] = 8'($urandom);
            endcase
        end
        if ($urandom_range(0, 4) != 0) begin
            copies = $urandom_range(1, 3);
            repeat (copies) begin
                q = $urandom_range(0, len_img - 1);
                if (q > 0 && $urandom_range(0, 1) == 1)
                    img_b[q-1] = ($urandom_range(0, 1) == 1) ? BYTE_RET : BYTE_PAD;
                for (int i = 0; i < n && q + i < len_img; i++)
                    img_b[q+i] = sb.care[i] ? sb.sig[8*i +: 8] : 8'($urandom);
            end
        end
        for (int k = 0; k < len_img; k++)
            send_byte(img_b[k], img_c[k], k == len_img - 1);
    endtask

    initial begin
        logic [127:0] s;
        logic [15:0]  c;
        logic [4:0]   n;
        logic [31:0]  o;
        logic [31:0]  st;
        int           phase;
        int           pick;
        int           phase_end;

        sb = new();
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_in_valid        = 1'b0;
        i_data_byte       = '0;
        i_in_code_section = 1'b0;
        i_last_byte       = 1'b0;
        in_idle_pct       = 15;
        out_idle_pct      = 15;
        bytes_sent        = 0;
        images_sent       = 0;
        settings_used     = 1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: one-byte signature 0x00.
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(BYTE_PAD, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);

        // Three bytes with a wildcard in the middle, most negative offset and
        // a header skip that rules out the first occurrence.
        settle();
        load_config(128'h00C3_5590, 16'h0005, 5'd3, 32'h8000_0000, 32'd2);
        send_byte(8'h90, 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(BYTE_RET, 1'b0, 1'b0);
        send_byte(8'h90, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(BYTE_RET, 1'b0, 1'b1);
        send_byte(8'h90, 1'b1, 1'b0);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(BYTE_RET, 1'b1, 1'b0);
        send_byte(8'h90, 1'b1, 1'b0);
        send_byte(8'hAA, 1'b1, 1'b1);

        // Zero length acts as one, first byte a wildcard, largest offset.
        settle();
        load_config({128{1'b1}}, 16'h0000, 5'd0, 32'h7FFF_FFFF, 32'd0);
        send_byte(BYTE_PAD, 1'b1, 1'b1);
        send_byte(8'hAB, 1'b1, 1'b1);

        phase = 0;
        while (bytes_sent < ITEM_TARGET) begin
            settle();
            if (bytes_sent >= QUIET_FROM) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 35);
                out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 35);
            end

            s = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 3))
                0: s[7:0] = BYTE_PAD;
                1: s[7:0] = BYTE_RET;
                default: ;
            endcase
            // The first six settings walk through every extreme in turn.
            pick = (phase < 6) ? phase : $urandom_range(0, 5);
            case (pick)
                0: c = 16'hFFFF;
                1: c = 16'h0000;
                2: c = 16'hFFFE;
                default: c = 16'($urandom);
            endcase
            case (pick)
                0: n = 5'd16;
                1: n = 5'd31;
                2: n = 5'd0;
                3: n = 5'd17;
                default: n = 5'($urandom_range(1, 16));
            endcase
            case (pick)
                0: o = 32'h8000_0000;
                1: o = 32'h7FFF_FFFF;
                2: o = 32'hFFFF_FFFF;
                3: o = 32'd0;
                4: o = 32'($urandom_range(0, 64)) - 32'd32;
                default: o = $urandom;
            endcase
            case (pick)
                0: st = 32'd0;
                1: st = 32'hFFFF_FFFF;
                2: st = $urandom;
                default: st = 32'($urandom_range(0, 30));
            endcase
            load_config(s, c, n, o, st);

            phase_end = bytes_sent + $urandom_range(70, 130);
            while (bytes_sent < phase_end && bytes_sent < ITEM_TARGET)
                send_image();
            phase++;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.verdicts_due.size() != 0) begin
            $display("%0t: %0d image results never arrived", $time, sb.verdicts_due.size());
            sb.errors++;
        end

        $display("Streamed %0d bytes in %0d images over %0d register settings.",
                 bytes_sent, images_sent, settings_used);
        $display("Results: %0d at function starts, %0d fallback matches, %0d without match.",
                 sb.fn_verdicts, sb.fallback_verdicts, sb.empty_verdicts);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
